// ===== hw/rtl/wbsf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and register codes for the 3x3 window filter
// no dependencies; used by every other file of the block but wbsf_ram
package wbsf_pkg;

  // pixel and configuration field widths
  localparam int PixW    = 8;
  localparam int WidthW  = 11;
  localparam int HeightW = 12;
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 2;

  // line store depth default
  localparam int MaxWidthDef = 1024;

  // smallest usable frame dimension
  localparam int MinDim = 3;

  // register reset values
  localparam logic [WidthW-1:0]  WidthRst  = 11'd512;
  localparam logic [HeightW-1:0] HeightRst = 12'd512;

  // box sum width (nine 8-bit pixels) and divide-by-nine reciprocal
  localparam int SumW      = 12;
  localparam int RecipW    = 12;
  localparam logic [RecipW-1:0] Div9Recip = 12'd3641;
  localparam int Div9Shift = 15;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } wbsf_reg_e;

  // filter kernels
  typedef enum logic {
    MODE_BLUR    = 1'b0,
    MODE_SHARPEN = 1'b1
  } wbsf_mode_e;

  // position flags of a pixel within its frame
  typedef struct packed {
    logic emit;
    logic last;
  } wbsf_pos_t;

endpackage

// ===== hw/rtl/wbsf_pix_if.sv =====
`timescale 1ns / 1ps
// valid/ready stream carrying one input pixel per transfer
// depends on wbsf_pkg
interface wbsf_pix_if;
  logic                     valid;
  logic                     ready;
  logic [wbsf_pkg::PixW-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== hw/rtl/wbsf_res_if.sv =====
`timescale 1ns / 1ps
// valid/ready stream carrying one filtered pixel and end-of-frame flag per transfer
// depends on wbsf_pkg
interface wbsf_res_if;
  logic                     valid;
  logic                     ready;
  logic [wbsf_pkg::PixW-1:0] pixel_out;
  logic                     frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== hw/rtl/wbsf_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module wbsf_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wbsf_cfg_pos.sv =====
`timescale 1ns / 1ps
// configuration registers and raster position counters
// depends on wbsf_pkg
module wbsf_cfg_pos #(
  parameter int MAX_WIDTH = wbsf_pkg::MaxWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wbsf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wbsf_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                             step_i,
  output logic [$clog2(MAX_WIDTH)-1:0]     col_o,
  output wbsf_pkg::wbsf_pos_t              pos_o,
  output wbsf_pkg::wbsf_mode_e             mode_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CmpW = ((ColW > wbsf_pkg::WidthW) ? ColW : wbsf_pkg::WidthW) + 2;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_WIDTH);
  localparam logic [CmpW-1:0] MinW = CmpW'(wbsf_pkg::MinDim);
  localparam logic [wbsf_pkg::HeightW-1:0] MinH = wbsf_pkg::HeightW'(wbsf_pkg::MinDim);

  logic [wbsf_pkg::WidthW-1:0]  width_q;
  logic [wbsf_pkg::HeightW-1:0] height_q;
  wbsf_pkg::wbsf_mode_e         mode_q;
  logic [ColW-1:0]              col_q, col_d;
  logic [wbsf_pkg::HeightW-1:0] row_q, row_d;

  logic [CmpW-1:0]              width_ext, eff_w, col_next_ext;
  logic [wbsf_pkg::HeightW-1:0] eff_h;
  logic                         row_end, frame_end;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wbsf_pkg::WidthRst;
      height_q <= wbsf_pkg::HeightRst;
      mode_q   <= wbsf_pkg::MODE_BLUR;
    end else if (cfg_we_i) begin
      unique case (wbsf_pkg::wbsf_reg_e'(cfg_idx_i))
        wbsf_pkg::REG_WIDTH:  width_q  <= cfg_data_i[wbsf_pkg::WidthW-1:0];
        wbsf_pkg::REG_HEIGHT: height_q <= cfg_data_i[wbsf_pkg::HeightW-1:0];
        wbsf_pkg::REG_MODE:   mode_q   <= wbsf_pkg::wbsf_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // effective frame size, clamped
  always_comb begin
    width_ext = CmpW'(width_q);
    if (width_ext < MinW) begin
      eff_w = MinW;
    end else if (width_ext > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = width_ext;
    end
    eff_h = (height_q < MinH) ? MinH : height_q;
  end

  // end of row and frame for the pixel at the current position
  assign col_next_ext = CmpW'(col_q) + CmpW'(1);
  assign row_end      = (col_next_ext >= eff_w);
  assign frame_end    = row_end &&
                        ({1'b0, row_q} + {{wbsf_pkg::HeightW{1'b0}}, 1'b1} >= {1'b0, eff_h});

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + wbsf_pkg::HeightW'(1);
    end
  end

  // position advances on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o      = col_q;
  assign pos_o.emit = (row_q >= wbsf_pkg::HeightW'(2)) && (col_q >= ColW'(2));
  assign pos_o.last = frame_end;
  assign mode_o     = mode_q;

endmodule

// ===== hw/rtl/wbsf_kernel.sv =====
`timescale 1ns / 1ps
// 3x3 kernel arithmetic: box mean or laplacian sharpen with clamp
// depends on wbsf_pkg
module wbsf_kernel (
  input  logic [wbsf_pkg::PixW-1:0] win_i [6],
  input  logic [wbsf_pkg::PixW-1:0] top_i,
  input  logic [wbsf_pkg::PixW-1:0] mid_i,
  input  logic [wbsf_pkg::PixW-1:0] bot_i,
  input  wbsf_pkg::wbsf_mode_e      mode_i,
  output logic [wbsf_pkg::PixW-1:0] pixel_o
);

  localparam int SumW  = wbsf_pkg::SumW;
  localparam int ProdW = wbsf_pkg::SumW + wbsf_pkg::RecipW;

  logic [SumW-1:0]         sum;
  logic [SumW-1:0]         centre9;
  logic [ProdW-1:0]        prod;
  logic [wbsf_pkg::PixW-1:0] mean;
  logic signed [SumW:0]    lap;
  logic [wbsf_pkg::PixW-1:0] sharp;

  // nine-tap sum
  assign sum = SumW'(win_i[0]) + SumW'(win_i[1]) + SumW'(win_i[2])
             + SumW'(win_i[3]) + SumW'(win_i[4]) + SumW'(win_i[5])
             + SumW'(top_i) + SumW'(mid_i) + SumW'(bot_i);

  // floor of sum / 9 by reciprocal multiply, exact over the sum range
  assign prod = ProdW'(sum) * ProdW'(wbsf_pkg::Div9Recip);
  assign mean = prod[wbsf_pkg::Div9Shift +: wbsf_pkg::PixW];

  // 8 x centre minus neighbours, as 9 x centre minus the full sum
  assign centre9 = (SumW'(win_i[4]) << 3) + SumW'(win_i[4]);
  assign lap     = $signed({1'b0, centre9}) - $signed({1'b0, sum});

  always_comb begin
    if (lap < 0) begin
      sharp = '0;
    end else if (lap > $signed((SumW+1)'(255))) begin
      sharp = '1;
    end else begin
      sharp = lap[wbsf_pkg::PixW-1:0];
    end
  end

  assign pixel_o = (mode_i == wbsf_pkg::MODE_SHARPEN) ? sharp : mean;

endmodule

// ===== hw/rtl/window_3x3_blur_sharpen_filter_unit.sv =====
`timescale 1ns / 1ps
// top level of the 3x3 window filter: line store, window, result register
// depends on wbsf_pkg, wbsf_pix_if, wbsf_res_if, wbsf_ram, wbsf_cfg_pos, wbsf_kernel
//
//   channel   direction  transfer on           payload
//   pix_in    in         valid & ready         pixel_in[7:0]
//   res_out   out        valid & ready         pixel_out[7:0], frame_last
//   cfg       in         cfg_we_i (no ready)   cfg_idx_i[1:0], cfg_data_i[11:0]
//
// one pixel per cycle sustained while results are taken; a result leaves once its pixel
// has passed the pixel register (with line store read), then the result register.
// the line store is one ram of {older row, newer row}, read on arrival and
// written back when the pixel moves on, so one read and one write port suffice.
// reset clears counters, window and handshake state; the line store is not cleared.
// input ready drops only while the result register holds a result that is not taken.
module window_3x3_blur_sharpen_filter_unit #(
  parameter int MAX_WIDTH = wbsf_pkg::MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wbsf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wbsf_pkg::CfgW-1:0]    cfg_data_i,
  wbsf_pix_if.sink                     pix_in,
  wbsf_res_if.source                   res_out
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int PixW = wbsf_pkg::PixW;

  logic                 in_acc;
  logic [ColW-1:0]      col;
  wbsf_pkg::wbsf_pos_t  pos;
  wbsf_pkg::wbsf_mode_e mode;

  logic                 s1_valid_q;
  logic [PixW-1:0]      s1_px_q;
  logic [ColW-1:0]      s1_col_q;
  wbsf_pkg::wbsf_pos_t  s1_pos_q;
  logic                 s1_adv;

  logic [2*PixW-1:0]    ram_rdata;
  logic [PixW-1:0]      top, mid;
  logic [PixW-1:0]      win_q [6];
  logic [PixW-1:0]      result;

  logic                 out_valid_q;
  logic [PixW-1:0]      out_px_q;
  logic                 out_last_q;

  // handshake: the pixel register moves on unless a result is blocked
  assign s1_adv       = s1_valid_q &&
                        (!s1_pos_q.emit || !out_valid_q || res_out.ready);
  assign pix_in.ready = !s1_valid_q || s1_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;

  // configuration and raster position
  wbsf_cfg_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_acc),
    .col_o      (col),
    .pos_o      (pos),
    .mode_o     (mode)
  );

  // line store, entry holds {row two up, row one up} for one column
  wbsf_ram #(
    .Width (2*PixW),
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_px_q}),
    .re_i    (in_acc),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  assign top = ram_rdata[2*PixW-1:PixW];
  assign mid = ram_rdata[PixW-1:0];

  // pixel register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pos_q   <= '0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_pos_q   <= pos;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q  <= pix_in.pixel_in;
      s1_col_q <= col;
    end
  end

  // kernel over the two stored columns and the new column
  wbsf_kernel u_kernel (
    .win_i   (win_q),
    .top_i   (top),
    .mid_i   (mid),
    .bot_i   (s1_px_q),
    .mode_i  (mode),
    .pixel_o (result)
  );

  // window shift as each pixel moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_px_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.emit) begin
      out_px_q   <= result;
      out_last_q <= s1_pos_q.last;
    end
  end

  assign res_out.valid      = out_valid_q;
  assign res_out.pixel_out  = out_px_q;
  assign res_out.frame_last = out_last_q;

endmodule

// ===== hw/rtl/wbsf_chk.sv =====
`timescale 1ns / 1ps
// port-level checker for the 3x3 window filter, bound to the top level
// depends on wbsf_pkg and window_3x3_blur_sharpen_filter_unit
module wbsf_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [wbsf_pkg::PixW-1:0] out_pixel_i,
  input logic                     out_last_i
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_pixel_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // input is refused only when a result is blocked downstream
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without downstream stall");

  // a fresh result follows an input transfer that has passed
  // the pixel register and then the result register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an input transfer");

endmodule

bind window_3x3_blur_sharpen_filter_unit wbsf_chk u_wbsf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (res_out.valid),
  .out_ready_i (res_out.ready),
  .out_pixel_i (res_out.pixel_out),
  .out_last_i  (res_out.frame_last)
);
